// ===== hw/rtl/rtks_pkg.sv =====
// shared types and codes for the radix-4 trie key store
package rtks_pkg;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EXAM,
        S_NEWN,
        S_VREAD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        LW_NONE,
        LW_ROOT,
        LW_NEW,
        LW_LINK,
        LW_MARK
    } t_lwr;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic    load_in;
        logic    ra_child;
        logic    step;
        logic    alloc;
        t_lwr    lwr;
        logic    vwe;
        logic    res_en;
        t_status res_status;
        logic    res_use_val;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic lookup;
        logic full;
        logic key_zero;
        logic child_zero;
        logic has_value;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/rtks_ram.sv =====
// generic single-write, single-read ram with registered read data
module rtks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rtks_ctrl.sv =====
// controller state machine for the trie walk
module rtks_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rtks_pkg::t_sts i_sts,
    output rtks_pkg::t_cmd o_cmd
);
    import rtks_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.lwr  = LW_NONE;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_INIT: begin
                o_cmd.lwr = LW_ROOT;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.lookup && i_sts.full) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = ST_FULL;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXAM;
            end
            S_EXAM: begin
                if (i_sts.key_zero) begin
                    if (!i_sts.lookup) begin
                        o_cmd.lwr    = LW_MARK;
                        o_cmd.vwe    = 1'b1;
                        o_cmd.res_en = 1'b1;
                        n_state      = S_DONE;
                    end else if (i_sts.has_value) begin
                        n_state = S_VREAD;
                    end else begin
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_DONE;
                    end
                end else if (!i_sts.child_zero) begin
                    o_cmd.ra_child = 1'b1;
                    o_cmd.step     = 1'b1;
                end else if (i_sts.lookup) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.lwr   = LW_LINK;
                    o_cmd.alloc = 1'b1;
                    n_state     = S_NEWN;
                end
            end
            S_NEWN: begin
                o_cmd.lwr = LW_NEW;
                n_state   = S_READ;
            end
            S_VREAD: begin
                o_cmd.res_en      = 1'b1;
                o_cmd.res_use_val = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rtks_dp.sv =====
// datapath: node pool memories, walk registers and result registers
module rtks_dp #(
    parameter int POOL_NODES = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtks_pkg::t_cmd        i_cmd,
    output rtks_pkg::t_sts        o_sts,
    input  logic                  i_op,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_value_out
);
    import rtks_pkg::*;

    localparam int NW     = $clog2(POOL_NODES);
    localparam int DIGITS = (KEY_BITS + 1) / 2;
    localparam int KPW    = 2 * DIGITS;
    localparam int CW     = $clog2(DIGITS + 1);
    localparam int SW     = ((NW + 1 > CW) ? NW + 1 : CW) + 1;
    localparam int LW     = 4 * NW + 1;
    localparam int HV     = 4 * NW;
    localparam logic [1:0] DIGIT_MASK = 2'b11;

    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [NW-1:0]         r_node;
    logic [NW:0]           r_free;
    t_status               r_res_status;
    logic [VALUE_BITS-1:0] r_res_value;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [VALUE_BITS-1:0] r_out_value;

    logic [1:0]            w_digit;
    logic [NW-1:0]         w_child;
    logic [LW-1:0]         w_lrdata;
    logic [LW-1:0]         w_linked;
    logic [LW-1:0]         w_marked;
    logic                  w_lwe;
    logic [NW-1:0]         w_lwaddr;
    logic [LW-1:0]         w_lwdata;
    logic [NW-1:0]         w_lraddr;
    logic [VALUE_BITS-1:0] w_vrdata;
    logic [KPW-1:0]        w_kpad;
    logic [CW-1:0]         w_dcnt;
    logic                  w_out_free;

    assign w_digit = r_key[1:0] & DIGIT_MASK;
    assign w_kpad  = KPW'(r_key);

    always_comb begin
        w_dcnt = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (w_kpad[2*i +: 2] != 2'b00) begin
                w_dcnt = CW'(i + 1);
            end
        end
    end

    always_comb begin
        w_child  = '0;
        w_linked = w_lrdata;
        for (int j = 0; j < 4; j++) begin
            if (w_digit == 2'(j)) begin
                w_child              = w_lrdata[j*NW +: NW];
                w_linked[j*NW +: NW] = r_free[NW-1:0];
            end
        end
    end

    always_comb begin
        w_marked     = w_lrdata;
        w_marked[HV] = 1'b1;
    end

    always_comb begin
        w_lwe    = 1'b0;
        w_lwaddr = r_node;
        w_lwdata = '0;
        case (i_cmd.lwr)
            LW_ROOT: begin
                w_lwe    = 1'b1;
                w_lwaddr = '0;
            end
            LW_NEW: begin
                w_lwe = 1'b1;
            end
            LW_LINK: begin
                w_lwe    = 1'b1;
                w_lwdata = w_linked;
            end
            LW_MARK: begin
                w_lwe    = 1'b1;
                w_lwdata = w_marked;
            end
            default: begin
                w_lwe = 1'b0;
            end
        endcase
    end

    assign w_lraddr = i_cmd.ra_child ? w_child : r_node;

    rtks_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_NODES)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_lwe),
        .i_waddr (w_lwaddr),
        .i_wdata (w_lwdata),
        .i_raddr (w_lraddr),
        .o_rdata (w_lrdata)
    );

    rtks_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (POOL_NODES)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (i_cmd.vwe),
        .i_waddr (r_node),
        .i_wdata (r_value),
        .i_raddr (r_node),
        .o_rdata (w_vrdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
            r_node  <= '0;
        end else if (i_cmd.step) begin
            r_node <= w_child;
            r_key  <= r_key >> 2;
        end else if (i_cmd.alloc) begin
            r_node <= r_free[NW-1:0];
            r_key  <= r_key >> 2;
        end
        if (i_cmd.res_en) begin
            r_res_status <= i_cmd.res_status;
            r_res_value  <= i_cmd.res_use_val ? w_vrdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= (NW + 1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.alloc) begin
                r_free <= r_free + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_sts.lookup     = (r_op == OP_LOOKUP);
    assign o_sts.full       = (SW'(r_free) + SW'(w_dcnt)) > SW'(POOL_NODES);
    assign o_sts.key_zero   = (r_key == '0);
    assign o_sts.child_zero = (w_child == '0);
    assign o_sts.has_value  = w_lrdata[HV];
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value_out = r_out_value;

endmodule

// ===== hw/rtl/radix4_trie_key_store.sv =====
// radix-4 trie key store top level
// one item at a time; a lookup passes CHECK, READ, then EXAM once per key digit (then VREAD when the value is read)
// an insert adds NEWN and another READ for each newly allocated node
// each digit is a dependent links read
// a finished result waits in the output register while the next item is taken
// after reset the INIT state clears the root node before the first item is accepted
module radix4_trie_key_store #(
    parameter int POOL_NODES = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_value_out
);
    import rtks_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rtks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rtks_dp #(
        .POOL_NODES (POOL_NODES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

endmodule

// ===== hw/rtl/rtks_chk.sv =====
// port-level checker for the radix-4 trie key store, bound to the top level
module rtks_chk #(
    parameter int VALUE_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [1:0]            o_status,
    input logic [VALUE_BITS-1:0] o_value_out
);
    import rtks_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_value_out))
        else $error("result changed while stalled");

    // only a successful transfer carries data
    a_zero_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_value_out == '0)
        else $error("nonzero value with failing status");

    // one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind radix4_trie_key_store rtks_chk #(.VALUE_BITS(VALUE_BITS)) u_chk (.*);
